@@ hw/rtl/ccbr_pkg.sv @@
// Shared types and constants of the center-crop bilinear resize unit.
`default_nettype none
package ccbr_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int DEF_OUT_SIZE   = 160;

   localparam int DIM_W   = 10;
   localparam int COORD_W = 9;
   localparam int PIX_W   = 8;
   localparam int RES_W   = 16;
   localparam int BIAS    = 32640;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // neighbor order of the four frame reads: bit 1 picks the row, bit 0 the column
   localparam logic [1:0] NBR_TL = 2'd0;
   localparam logic [1:0] NBR_TR = 2'd1;
   localparam logic [1:0] NBR_BL = 2'd2;
   localparam logic [1:0] NBR_BR = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       map;
      logic       divide;
      logic       frac;
      logic       weigh;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       norm;
      logic       load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic bad;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ hw/rtl/ccbr_ctrl.sv @@
// Sequencer of the resize unit: handshakes and datapath commands.
`default_nettype none
module ccbr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_func,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ccbr_pkg::dp_stat_type stat,
   output ccbr_pkg::dp_cmd_type      cmd
);
   import ccbr_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_MAP  = 13'b0000000000010,
      S_DIV  = 13'b0000000000100,
      S_FRC  = 13'b0000000001000,
      S_WGT  = 13'b0000000010000,
      S_RD0  = 13'b0000000100000,
      S_RD1  = 13'b0000001000000,
      S_RD2  = 13'b0000010000000,
      S_RD3  = 13'b0000100000000,
      S_DR1  = 13'b0001000000000,
      S_DR2  = 13'b0010000000000,
      S_NORM = 13'b0100000000000,
      S_FIN  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_func == FUNC_SAMPLE) begin
               state_in = stat.bad ? S_FIN : S_MAP;
            end
         end
         S_MAP:  state_in = S_DIV;
         S_DIV:  state_in = S_FRC;
         S_FRC:  state_in = S_WGT;
         S_WGT:  state_in = S_RD0;
         S_RD0:  state_in = S_RD1;
         S_RD1:  state_in = S_RD2;
         S_RD2:  state_in = S_RD3;
         S_RD3:  state_in = S_DR1;
         S_DR1:  state_in = S_DR2;
         S_DR2:  state_in = S_NORM;
         S_NORM: state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.accept   = accept;
      cmd.map      = (state_ff == S_MAP);
      cmd.divide   = (state_ff == S_DIV);
      cmd.frac     = (state_ff == S_FRC);
      cmd.weigh    = (state_ff == S_WGT);
      cmd.rd_en    = (state_ff == S_RD0) || (state_ff == S_RD1) ||
                     (state_ff == S_RD2) || (state_ff == S_RD3);
      cmd.norm     = (state_ff == S_NORM);
      cmd.load_out = (state_ff == S_FIN) && out_free;
      priority if (state_ff == S_RD1) begin
         cmd.rd_sel = NBR_TR;
      end else if (state_ff == S_RD2) begin
         cmd.rd_sel = NBR_BL;
      end else if (state_ff == S_RD3) begin
         cmd.rd_sel = NBR_BR;
      end else begin
         cmd.rd_sel = NBR_TL;
      end
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // frame reads never share the port cycle with a load write
   a_port_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !req_ready)
      else $error("frame read while items are accepted");

   a_fin_emits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIN) && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not presented");

endmodule
`default_nettype wire

@@ hw/rtl/ccbr_dp.sv @@
// Datapath of the resize unit: frame memory, coordinate mapping, blend, scaling.
`default_nettype none
module ccbr_dp #(
   parameter int MAX_WIDTH  = ccbr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ccbr_pkg::DEF_MAX_HEIGHT,
   parameter int OUT_SIZE   = ccbr_pkg::DEF_OUT_SIZE
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ccbr_pkg::dp_cmd_type              cmd,
   output ccbr_pkg::dp_stat_type                  stat,
   input  wire logic                              req_func,
   input  wire logic [ccbr_pkg::COORD_W-1:0]      req_col,
   input  wire logic [ccbr_pkg::COORD_W-1:0]      req_row,
   input  wire logic [ccbr_pkg::PIX_W-1:0]        req_red,
   input  wire logic [ccbr_pkg::PIX_W-1:0]        req_green,
   input  wire logic [ccbr_pkg::PIX_W-1:0]        req_blue,
   input  wire logic                              csr_wen,
   input  wire logic                              csr_index,
   input  wire logic [ccbr_pkg::DIM_W-1:0]        csr_wdata,
   output logic signed [ccbr_pkg::RES_W-1:0]      rsp_out_red,
   output logic signed [ccbr_pkg::RES_W-1:0]      rsp_out_green,
   output logic signed [ccbr_pkg::RES_W-1:0]      rsp_out_blue,
   output logic                                   rsp_bad_coord
);
   import ccbr_pkg::*;

   function automatic int trail_zeros(input int v);
      int  n;
      logic done;
      n    = 0;
      done = 1'b0;
      for (int i = 0; i < 31; i++) begin
         if (!done && v[i] == 1'b0) begin
            n++;
         end else begin
            done = 1'b1;
         end
      end
      return n;
   endfunction

   localparam int D     = 2 * OUT_SIZE;
   localparam int DD    = D * D;
   localparam int TZD   = trail_zeros(D);
   localparam int OD1   = D >> TZD;
   localparam int CL1   = $clog2(OD1);
   localparam int NXW   = $clog2(1023 * 1023 + D * 511 + 1) + 1;
   localparam int NUW   = NXW - 1;
   localparam int NB1   = NUW - TZD;
   localparam int K1    = NB1 + CL1;
   localparam int QW    = DIM_W;
   localparam int PW1   = 2 * NB1 + 1 + QW;
   localparam logic [63:0] RC1_L = ((64'd1 << K1) + 64'(OD1) - 64'd1) / 64'(OD1);
   localparam logic [NB1:0] RC1 = RC1_L[NB1:0];

   localparam int FW    = $clog2(D) > 0 ? $clog2(D) : 1;
   localparam int WXW   = $clog2(D + 1);
   localparam int WW    = $clog2(DD + 1);
   localparam int SW    = $clog2(255 * DD + 1);
   localparam int NW2   = SW + 9;
   localparam int TZDD  = 2 * TZD;
   localparam int OD2   = OD1 * OD1;
   localparam int CL2   = $clog2(OD2);
   localparam int NB2   = NW2 - TZDD;
   localparam int K2    = NB2 + CL2;
   localparam int QNW   = 17;
   localparam int PW2   = 2 * NB2 + 1 + QNW;
   localparam logic [63:0] RC2_L = ((64'd1 << K2) + 64'(OD2) - 64'd1) / 64'(OD2);
   localparam logic [NB2:0] RC2 = RC2_L[NB2:0];

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int WCAP  = MAX_WIDTH > 1023 ? 1023 : MAX_WIDTH;
   localparam int HCAP  = MAX_HEIGHT > 1023 ? 1023 : MAX_HEIGHT;

   // configuration
   logic [DIM_W-1:0] cfg_w_ff, cfg_w_in, cfg_h_ff, cfg_h_in;
   logic [DIM_W-1:0] w_eff, h_eff, side;
   logic [DIM_W-2:0] ox, oy;

   // sample pipeline
   logic [COORD_W-1:0]     col_ff, row_ff;
   logic                   bad_ff;
   logic signed [NXW-1:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic [QW-1:0]          qx_ff, qx_in, qy_ff, qy_in;
   logic [DIM_W-1:0]       cx0_ff, cx0_in, cx1_ff, cx1_in, cy0_ff, cy0_in, cy1_ff, cy1_in;
   logic [FW-1:0]          fx_ff, fx_in, fy_ff, fy_in;
   logic [WXW-1:0]         gx_ff, gx_in, gy_ff, gy_in;
   logic [WW-1:0]          wt_ff [4];
   logic [WW-1:0]          wt_in [4];
   logic [23:0]            rdata_ff;
   logic [1:0]             sel_d1_ff;
   logic                   vld_d1_ff, vld_d2_ff;
   logic [SW-1:0]          prod_ff [3];
   logic [SW-1:0]          prod_in [3];
   logic [SW-1:0]          acc_ff [3];
   logic [QNW-1:0]         qn_ff [3];
   logic [QNW-1:0]         qn_in [3];
   logic [RES_W-1:0]       res [3];

   logic [23:0]            mem [DEPTH];
   logic [AW-1:0]          waddr, raddr, addr;
   logic                   wr_en, in_range;
   logic [DIM_W-1:0]       ry, rx;

   assign stat.bad = (int'(req_col) >= OUT_SIZE) || (int'(req_row) >= OUT_SIZE);

   // register writes
   always_comb begin
      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  cfg_w_in = csr_wdata;
            REG_FRAME_HEIGHT: cfg_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= DIM_W'(160);
         cfg_h_ff <= DIM_W'(160);
      end else begin
         cfg_w_ff <= cfg_w_in;
         cfg_h_ff <= cfg_h_in;
      end
   end

   always_comb begin
      if (cfg_w_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (int'(cfg_w_ff) > WCAP) begin
         w_eff = DIM_W'(WCAP);
      end else begin
         w_eff = cfg_w_ff;
      end
      if (cfg_h_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (int'(cfg_h_ff) > HCAP) begin
         h_eff = DIM_W'(HCAP);
      end else begin
         h_eff = cfg_h_ff;
      end
      side = (w_eff < h_eff) ? w_eff : h_eff;
      ox   = (DIM_W-1)'((w_eff - side) >> 1);
      oy   = (DIM_W-1)'((h_eff - side) >> 1);
   end

   // source position in 1/D pixel units: (2c+1)*side - OUT + D*offset
   always_comb begin
      logic [2*DIM_W-1:0] spx, spy;
      spx   = (2*DIM_W)'({col_ff, 1'b1}) * (2*DIM_W)'(side);
      spy   = (2*DIM_W)'({row_ff, 1'b1}) * (2*DIM_W)'(side);
      nx_in = NXW'(spx) + NXW'(D) * NXW'(ox) - NXW'(OUT_SIZE);
      ny_in = NXW'(spy) + NXW'(D) * NXW'(oy) - NXW'(OUT_SIZE);
   end

   // floor(n / D) for n >= 0: shift out the power of two, reciprocal for the odd part
   always_comb begin
      logic [NB1-1:0] nxs, nys;
      logic [PW1-1:0] px, py;
      nxs   = NB1'(nx_ff[NUW-1:0] >> TZD);
      nys   = NB1'(ny_ff[NUW-1:0] >> TZD);
      px    = PW1'(nxs) * PW1'(RC1);
      py    = PW1'(nys) * PW1'(RC1);
      qx_in = px[K1 +: QW];
      qy_in = py[K1 +: QW];
   end

   // fraction and clamped neighbor coordinates; a negative position has floor -1
   always_comb begin
      logic [NXW-1:0] rx_f, ry_f;
      logic [DIM_W:0] incx, incy;
      logic           xneg, yneg;
      xneg   = nx_ff[NXW-1];
      yneg   = ny_ff[NXW-1];
      rx_f   = xneg ? (NXW'(nx_ff) + NXW'(D)) : (NXW'(nx_ff) - NXW'(qx_ff) * NXW'(D));
      ry_f   = yneg ? (NXW'(ny_ff) + NXW'(D)) : (NXW'(ny_ff) - NXW'(qy_ff) * NXW'(D));
      fx_in  = rx_f[FW-1:0];
      fy_in  = ry_f[FW-1:0];
      gx_in  = WXW'(D) - WXW'(fx_in);
      gy_in  = WXW'(D) - WXW'(fy_in);
      incx   = (DIM_W+1)'(qx_ff) + 1'b1;
      incy   = (DIM_W+1)'(qy_ff) + 1'b1;
      cx0_in = xneg ? '0 : qx_ff;
      cy0_in = yneg ? '0 : qy_ff;
      cx1_in = xneg ? '0 : ((incx >= (DIM_W+1)'(w_eff)) ? w_eff - 1'b1 : DIM_W'(incx));
      cy1_in = yneg ? '0 : ((incy >= (DIM_W+1)'(h_eff)) ? h_eff - 1'b1 : DIM_W'(incy));
   end

   always_comb begin
      wt_in[NBR_TL] = WW'(gx_ff) * WW'(gy_ff);
      wt_in[NBR_TR] = WW'(fx_ff) * WW'(gy_ff);
      wt_in[NBR_BL] = WW'(gx_ff) * WW'(fy_ff);
      wt_in[NBR_BR] = WW'(fx_ff) * WW'(fy_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         col_ff <= req_col;
         row_ff <= req_row;
         bad_ff <= stat.bad;
      end
      if (cmd.map) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
      end
      if (cmd.divide) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
      if (cmd.frac) begin
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         gx_ff  <= gx_in;
         gy_ff  <= gy_in;
         cx0_ff <= cx0_in;
         cx1_ff <= cx1_in;
         cy0_ff <= cy0_in;
         cy1_ff <= cy1_in;
      end
      if (cmd.weigh) begin
         for (int i = 0; i < 4; i++) begin
            wt_ff[i] <= wt_in[i];
         end
      end
   end

   // single frame port: load writes in the accept cycle, sample reads later
   assign in_range = (int'(req_col) < MAX_WIDTH) && (int'(req_row) < MAX_HEIGHT);
   assign wr_en    = cmd.accept && (req_func == FUNC_LOAD) && in_range;
   assign waddr    = AW'(int'(req_row) * MAX_WIDTH + int'(req_col));
   assign ry       = cmd.rd_sel[1] ? cy1_ff : cy0_ff;
   assign rx       = cmd.rd_sel[0] ? cx1_ff : cx0_ff;
   assign raddr    = AW'(int'(ry) * MAX_WIDTH + int'(rx));
   assign addr     = wr_en ? waddr : raddr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= {req_blue, req_green, req_red};
      end
      rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d1_ff <= 1'b0;
         vld_d2_ff <= 1'b0;
      end else begin
         vld_d1_ff <= cmd.rd_en;
         vld_d2_ff <= vld_d1_ff;
      end
      sel_d1_ff <= cmd.rd_sel;
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod_in[ch] = SW'(rdata_ff[PIX_W*ch +: PIX_W]) * SW'(wt_ff[sel_d1_ff]);
      end
   end

   // round((v - 127.5) * 256): floor((256*S + DD/2) / DD) - 32640
   always_comb begin
      logic [NW2-1:0] nn;
      logic [NB2-1:0] ns;
      logic [PW2-1:0] pn;
      for (int ch = 0; ch < 3; ch++) begin
         nn        = (NW2'(acc_ff[ch]) << 8) + NW2'(DD / 2);
         ns        = NB2'(nn >> TZDD);
         pn        = PW2'(ns) * PW2'(RC2);
         qn_in[ch] = pn[K2 +: QNW];
      end
   end

   always_comb begin
      logic [QNW:0] diff;
      for (int ch = 0; ch < 3; ch++) begin
         diff    = (QNW+1)'(qn_ff[ch]) - (QNW+1)'(BIAS);
         res[ch] = bad_ff ? '0 : diff[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         if (vld_d1_ff) begin
            prod_ff[ch] <= prod_in[ch];
         end
         if (cmd.weigh) begin
            acc_ff[ch] <= '0;
         end else if (vld_d2_ff) begin
            acc_ff[ch] <= acc_ff[ch] + prod_ff[ch];
         end
         if (cmd.norm) begin
            qn_ff[ch] <= qn_in[ch];
         end
      end
      if (cmd.load_out) begin
         rsp_out_red   <= res[0];
         rsp_out_green <= res[1];
         rsp_out_blue  <= res[2];
         rsp_bad_coord <= bad_ff;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/center_crop_bilinear_resize_unit.sv @@
// Center-crop bilinear resize unit: top level.
//
// Input channel req_*: func 0 stores one RGB pixel at (col,row) of the frame
// memory and gives no result; func 1 samples output pixel (col,row) of the
// square output grid and gives one rsp_* item: three standardized channels
// in Q1.15, or zeros with bad_coord set when col or row lies off the grid.
// frame_width / frame_height are written on csr_*; the user must do so only
// while the unit is idle, as the unit does not enforce it. A load is written
// to frame memory in its accept cycle. A sample item goes through mapping,
// divide, fraction, weights, four frame reads through the single memory
// port, two blend stages, scaling; its result is then registered. An off-grid
// sample skips these steps. No new item is taken until a sample is finished.
// A result waits in the output register until taken; loads are accepted
// meanwhile, a sample proceeds and holds at its last step if the register
// is still full. Reset restores both frame sizes to 160 and empties the
// unit; frame memory contents are not cleared and must be loaded first.
`default_nettype none
module center_crop_bilinear_resize_unit #(
   parameter int MAX_WIDTH  = ccbr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ccbr_pkg::DEF_MAX_HEIGHT,
   parameter int OUT_SIZE   = ccbr_pkg::DEF_OUT_SIZE
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_func,
   input  wire logic [ccbr_pkg::COORD_W-1:0]      req_col,
   input  wire logic [ccbr_pkg::COORD_W-1:0]      req_row,
   input  wire logic [ccbr_pkg::PIX_W-1:0]        req_red,
   input  wire logic [ccbr_pkg::PIX_W-1:0]        req_green,
   input  wire logic [ccbr_pkg::PIX_W-1:0]        req_blue,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [ccbr_pkg::RES_W-1:0]      rsp_out_red,
   output logic signed [ccbr_pkg::RES_W-1:0]      rsp_out_green,
   output logic signed [ccbr_pkg::RES_W-1:0]      rsp_out_blue,
   output logic                                   rsp_bad_coord,
   input  wire logic                              csr_wen,
   input  wire logic                              csr_index,
   input  wire logic [ccbr_pkg::DIM_W-1:0]        csr_wdata
);
   import ccbr_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ccbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ccbr_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .OUT_SIZE   (OUT_SIZE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_func      (req_func),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_bad_coord (rsp_bad_coord)
   );

endmodule
`default_nettype wire

@@ verif/tb_center_crop_bilinear_resize_unit.sv @@
// Testbench for the center-crop bilinear resize unit with a self-checking scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_center_crop_bilinear_resize_unit;
   import ccbr_pkg::*;

   localparam int OUT_GRID  = DEF_OUT_SIZE;
   localparam int STORE_W   = DEF_MAX_WIDTH;
   localparam int STORE_H   = DEF_MAX_HEIGHT;
   localparam int STALL_MAX = 20000;

   typedef struct packed {
      logic signed [RES_W-1:0] red;
      logic signed [RES_W-1:0] green;
      logic signed [RES_W-1:0] blue;
      logic                    bad;
   } pixel_out_type;

   class resize_scoreboard;
      logic [23:0]   frame_mem [int];
      int unsigned   width_reg = 160;
      int unsigned   height_reg = 160;
      pixel_out_type pending_px [$];
      int            errors = 0;
      int            samples_done = 0;
      int            loads_done = 0;

      function void write_reg(logic idx, int unsigned value);
         if (idx == REG_FRAME_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      function longint fdiv(longint a, longint b);
         longint q;
         q = a / b;
         if ((a % b) != 0 && a < 0) q--;
         return q;
      endfunction

      function int unsigned eff(int unsigned v, int unsigned mx);
         if (v == 0) return 1;
         return (v > mx) ? mx : v;
      endfunction

      // integer part and fraction of one source axis, in 1/(2*OUT_GRID) units
      function void axis_map(int c, int unsigned dim, int unsigned side,
                             output longint base, output longint frac);
         longint n;
         longint d;
         d = 2 * OUT_GRID;
         n = (2 * longint'(c) + 1) * side - OUT_GRID + d * ((dim - side) / 2);
         base = fdiv(n, d);
         frac = n - base * d;
      endfunction

      // clamped frame taps that a sample at (c,r) reads
      function void taps(int c, int r, output int xa, output int xb,
                         output int ya, output int yb);
         int unsigned w, h, side;
         longint bx, by, fx, fy;
         w = eff(width_reg, STORE_W);
         h = eff(height_reg, STORE_H);
         side = (w < h) ? w : h;
         axis_map(c, w, side, bx, fx);
         axis_map(r, h, side, by, fy);
         xa = int'((bx < 0) ? 0 : ((bx > w - 1) ? w - 1 : bx));
         xb = int'((bx + 1 < 0) ? 0 : ((bx + 1 > w - 1) ? w - 1 : bx + 1));
         ya = int'((by < 0) ? 0 : ((by > h - 1) ? h - 1 : by));
         yb = int'((by + 1 < 0) ? 0 : ((by + 1 > h - 1) ? h - 1 : by + 1));
      endfunction

      function longint chan(int x, int y, int ch);
         logic [23:0] px;
         px = frame_mem.exists(y * STORE_W + x) ? frame_mem[y * STORE_W + x] : 24'd0;
         return longint'((px >> (8 * ch)) & 24'hFF);
      endfunction

      function void note_item(logic func, int c, int r, logic [7:0] rd,
                              logic [7:0] gr, logic [7:0] bl);
         pixel_out_type e;
         int xa, xb, ya, yb, ch;
         int unsigned w, h, side;
         longint bx, by, fx, fy, d, dd, s, q;
         if (func == FUNC_LOAD) begin
            frame_mem[r * STORE_W + c] = {bl, gr, rd};
            loads_done++;
            return;
         end
         e = '0;
         if (c >= OUT_GRID || r >= OUT_GRID) begin
            e.bad = 1'b1;
         end else begin
            w = eff(width_reg, STORE_W);
            h = eff(height_reg, STORE_H);
            side = (w < h) ? w : h;
            axis_map(c, w, side, bx, fx);
            axis_map(r, h, side, by, fy);
            taps(c, r, xa, xb, ya, yb);
            d = 2 * OUT_GRID;
            dd = d * d;
            for (ch = 0; ch < 3; ch++) begin
               s = chan(xa, ya, ch) * (d - fx) * (d - fy) + chan(xb, ya, ch) * fx * (d - fy)
                 + chan(xa, yb, ch) * (d - fx) * fy + chan(xb, yb, ch) * fx * fy;
               q = fdiv(s * 256 - longint'(BIAS) * dd + dd / 2, dd);
               if (q < -32768) q = -32768;
               if (q > 32767) q = 32767;
               case (ch)
                  0: e.red = q[15:0];
                  1: e.green = q[15:0];
                  default: e.blue = q[15:0];
               endcase
            end
         end
         pending_px.push_back(e);
      endfunction

      function void check_result(pixel_out_type got);
         pixel_out_type e;
         samples_done++;
         if (pending_px.size() == 0) begin
            $display("%0t: result with none expected: %h", $time, got);
            errors++;
            return;
         end
         e = pending_px.pop_front();
         if (got.red !== e.red) begin
            $display("%0t: out_red exp %0d got %0d", $time, e.red, got.red);
            errors++;
         end
         if (got.green !== e.green) begin
            $display("%0t: out_green exp %0d got %0d", $time, e.green, got.green);
            errors++;
         end
         if (got.blue !== e.blue) begin
            $display("%0t: out_blue exp %0d got %0d", $time, e.blue, got.blue);
            errors++;
         end
         if (got.bad !== e.bad) begin
            $display("%0t: bad_coord exp %0b got %0b", $time, e.bad, got.bad);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = 1'b0;
   logic [COORD_W-1:0] req_col = '0;
   logic [COORD_W-1:0] req_row = '0;
   logic [PIX_W-1:0] req_red = '0;
   logic [PIX_W-1:0] req_green = '0;
   logic [PIX_W-1:0] req_blue = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [RES_W-1:0] rsp_out_red;
   logic signed [RES_W-1:0] rsp_out_green;
   logic signed [RES_W-1:0] rsp_out_blue;
   logic rsp_bad_coord;
   logic csr_wen = 1'b0;
   logic csr_index = REG_FRAME_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;

   resize_scoreboard sb = new();
   int tx_idle_pct = 30;
   int rx_idle_pct = 69;
   int rx_hold = 0;
   int quiet_cycles = 0;

   center_crop_bilinear_resize_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: random back-pressure plus an occasional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_bad_coord});
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     sb.pending_px.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_item(logic func, int c, int r, logic [7:0] rd,
                            logic [7:0] gr, logic [7:0] bl);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_col <= COORD_W'(c);
      req_row <= COORD_W'(r);
      req_red <= rd;
      req_green <= gr;
      req_blue <= bl;
      do @(posedge clock); while (!req_ready);
      sb.note_item(func, c, r, rd, gr, bl);
   endtask

   // load any unwritten tap first, then issue the sample
   task automatic sample_at(int c, int r, int shade);
      int xs [4];
      int ys [4];
      int k;
      logic [7:0] v;
      if (c < OUT_GRID && r < OUT_GRID) begin
         sb.taps(c, r, xs[0], xs[1], ys[0], ys[2]);
         xs[2] = xs[0];
         xs[3] = xs[1];
         ys[1] = ys[0];
         ys[3] = ys[2];
         for (k = 0; k < 4; k++) begin
            if (!sb.frame_mem.exists(ys[k] * STORE_W + xs[k])) begin
               v = (shade == 1) ? 8'hFF : 8'h00;
               if (shade == 0) send_item(FUNC_LOAD, xs[k], ys[k], PIX_W'($urandom),
                                         PIX_W'($urandom), PIX_W'($urandom));
               else send_item(FUNC_LOAD, xs[k], ys[k], v, v, v);
            end
         end
      end
      send_item(FUNC_SAMPLE, c, r, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_px.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(value);
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic random_items(int count);
      int k, pick;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 65) sample_at($urandom_range(OUT_GRID - 1), $urandom_range(OUT_GRID - 1), 0);
         else if (pick < 75) sample_at($urandom_range(511), $urandom_range(OUT_GRID, 511), 0);
         else send_item(FUNC_LOAD, $urandom_range(511), $urandom_range(511),
                        PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
      end
   endtask

   initial begin
      int unsigned widths [8] = '{0, 512, 1023, 1, 3, 37, 200, 97};
      int unsigned heights [8] = '{0, 512, 7, 1023, 640, 50, 120, 301};
      int p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: grid corners on the reset size, pixel extremes, off-grid codes
      sample_at(0, 0, 1);
      sample_at(OUT_GRID - 1, OUT_GRID - 1, 2);
      sample_at(0, OUT_GRID - 1, 1);
      sample_at(OUT_GRID - 1, 0, 2);
      sample_at(80, 80, 0);
      sample_at(OUT_GRID, 0, 0);
      sample_at(0, OUT_GRID, 0);
      sample_at(511, 511, 0);
      send_item(FUNC_LOAD, 511, 511, 8'hFF, 8'hFF, 8'hFF);
      send_item(FUNC_LOAD, 0, 0, 8'h00, 8'h00, 8'h00);
      sample_at(0, 0, 0);
      drain();

      for (p = 0; p < 8; p++) begin
         if (p == 3) begin
            tx_idle_pct = 69;
            rx_idle_pct = 30;
         end else if (p == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         write_csr(REG_FRAME_WIDTH, widths[p]);
         write_csr(REG_FRAME_HEIGHT, heights[p]);
         if (p == 1 || p == 6) rx_hold = 400;
         sample_at(0, 0, 0);
         sample_at(OUT_GRID - 1, OUT_GRID - 1, 0);
         random_items(40);
         drain();
      end

      $display("Covered %0d loads and %0d samples over 9 frame sizes, incl. degenerate,",
               sb.loads_done, sb.samples_done);
      $display("saturated and off-grid cases, under mixed back-pressure.");
      if (sb.errors == 0 && sb.pending_px.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/ccbr_pkg.sv
hw/rtl/ccbr_ctrl.sv
hw/rtl/ccbr_dp.sv
hw/rtl/center_crop_bilinear_resize_unit.sv
verif/tb_center_crop_bilinear_resize_unit.sv
